// ===== sv/c_string_literal_escaper_defines.svh =====
// Assertion macros used by the checker file of the string literal escaper.
`ifndef C_STRING_LITERAL_ESCAPER_DEFINES_SVH
`define C_STRING_LITERAL_ESCAPER_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define CSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cse_pkg.sv =====
// Types and constants of the C string literal escaper.
package cse_pkg;

    localparam int RUN_MAX = 12;
    localparam int CNT_W   = $clog2(RUN_MAX + 1);

    typedef logic [6:0]       char_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // All characters caused by one input byte, first character in entry 0.
    typedef struct packed {
        char_t [RUN_MAX-1:0] chars;
        cnt_t                count;
    } run_t;

    localparam logic [7:0] WRAP_RESET = 8'd74;
    localparam logic [7:0] COL_CLOSED = 8'd0;
    localparam logic [7:0] COL_OPEN   = 8'd3;
    localparam logic [7:0] COL_MAX    = 8'd255;
    localparam logic [7:0] PLAIN_LO   = 8'h21;
    localparam logic [7:0] PLAIN_HI   = 8'h7E;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;
    localparam logic [7:0] OCT1_MAX   = 8'd7;
    localparam logic [7:0] OCT2_MAX   = 8'd63;
    localparam logic [7:0] BYTE_BSL   = 8'h5C;
    localparam logic [7:0] BYTE_QUOTE = 8'h22;

    localparam char_t CH_SPACE     = 7'h20;
    localparam char_t CH_QUOTE     = 7'h22;
    localparam char_t CH_NEWLINE   = 7'h0A;
    localparam char_t CH_COMMA     = 7'h2C;
    localparam char_t CH_BACKSLASH = 7'h5C;

    // Octal digit as an ASCII character.
    function automatic char_t octal_char(input logic [2:0] digit);
        return {4'b0110, digit};
    endfunction

endpackage

// ===== sv/cse_if.sv =====
// Valid/ready channel interfaces for input bytes and output characters.
interface cse_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface cse_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last_of_run;

    modport source (output valid, output character, output last_of_run, input ready);
    modport sink (input valid, input character, input last_of_run, output ready);
endinterface

// ===== sv/cse_encoder.sv =====
// Builds the full character run of one byte and the column that follows it.
module cse_encoder (
    input  logic [7:0]    data_byte,
    input  logic          end_of_data,
    input  logic [7:0]    column,
    input  logic [7:0]    wrap_column,
    output cse_pkg::run_t run,
    output logic [7:0]    column_next
);
    import cse_pkg::*;

    logic       plain;
    logic       simple_esc;
    logic [2:0] width;
    logic [7:0] base;
    logic [8:0] col_sum;
    cnt_t       n;

    assign simple_esc = (data_byte == BYTE_BSL) || (data_byte == BYTE_QUOTE);
    assign plain = (data_byte >= PLAIN_LO) && (data_byte <= PLAIN_HI) && !simple_esc
                   && !((data_byte >= DIGIT_LO) && (data_byte <= DIGIT_HI));

    // Line width of the byte; an octal escape counts only its significant digits.
    always_comb
    begin
        if (plain)
            width = 3'd1;
        else if (simple_esc)
            width = 3'd2;
        else
            width = 3'd2 + {2'b00, data_byte > OCT1_MAX} + {2'b00, data_byte > OCT2_MAX};
    end

    always_comb
    begin
        run.chars = '{default: CH_SPACE};
        n         = '0;
        base      = column;

        if (column == COL_CLOSED)
        begin
            run.chars[0] = CH_SPACE;
            run.chars[1] = CH_SPACE;
            run.chars[2] = CH_QUOTE;
            n            = cnt_t'(3);
            base         = COL_OPEN;
        end
        else if (column > wrap_column)
        begin
            run.chars[0] = CH_QUOTE;
            run.chars[1] = CH_NEWLINE;
            run.chars[2] = CH_SPACE;
            run.chars[3] = CH_SPACE;
            run.chars[4] = CH_QUOTE;
            n            = cnt_t'(5);
            base         = COL_OPEN;
        end

        if (plain)
        begin
            run.chars[n] = data_byte[6:0];
            n            = n + cnt_t'(1);
        end
        else if (simple_esc)
        begin
            run.chars[n]              = CH_BACKSLASH;
            run.chars[n + cnt_t'(1)]  = data_byte[6:0];
            n                         = n + cnt_t'(2);
        end
        else
        begin
            run.chars[n]             = CH_BACKSLASH;
            run.chars[n + cnt_t'(1)] = octal_char({1'b0, data_byte[7:6]});
            run.chars[n + cnt_t'(2)] = octal_char(data_byte[5:3]);
            run.chars[n + cnt_t'(3)] = octal_char(data_byte[2:0]);
            n                        = n + cnt_t'(4);
        end

        if (end_of_data)
        begin
            run.chars[n]             = CH_QUOTE;
            run.chars[n + cnt_t'(1)] = CH_COMMA;
            run.chars[n + cnt_t'(2)] = CH_NEWLINE;
            n                        = n + cnt_t'(3);
        end

        run.count = n;
    end

    assign col_sum = {1'b0, base} + {6'd0, width};

    always_comb
    begin
        if (end_of_data)
            column_next = COL_CLOSED;
        else if (col_sum[8])
            column_next = COL_MAX;
        else
            column_next = col_sum[7:0];
    end

endmodule

// ===== sv/c_string_literal_escaper.sv =====
// C string literal escaper: turns raw bytes into quoted, line-wrapped C string text,
// one ASCII character per output transfer. A byte is taken into an input register,
// expanded combinationally into its complete run of 1 to 12 characters (line opening
// or break, escape, and the closing quote, comma and newline after the last byte), and
// the run is then shifted out of a result register at one character per cycle while
// the receiver is ready. A run holds 1 character for a plain character, 2 or 4 for an
// escape, plus 3 or 5 for a line opening or break and 3 after the last byte. The next
// byte is accepted while the current run is still being sent, so the output never
// idles as long as bytes keep arriving. wrap_column resets to 74; the user must write
// it only while idle, as nothing in the block itself enforces this.
module c_string_literal_escaper (
    input logic          clk,
    input logic          rst_n,
    cse_byte_if.sink     byte_ch,
    cse_char_if.source   char_ch,
    input logic          wrap_we,
    input logic [7:0]    wrap_wdata
);
    import cse_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eod_reg;
    logic [7:0] column_reg;
    logic [7:0] wrap_reg;
    run_t       run_reg;
    logic       run_valid_reg;
    cnt_t       idx_reg;

    run_t       enc_run;
    logic [7:0] enc_column;
    logic       in_take;
    logic       out_take;
    logic       run_done;
    logic       load;

    cse_encoder u_encoder (
        .data_byte   (in_byte_reg),
        .end_of_data (in_eod_reg),
        .column      (column_reg),
        .wrap_column (wrap_reg),
        .run         (enc_run),
        .column_next (enc_column)
    );

    assign out_take = char_ch.valid && char_ch.ready;
    assign run_done = out_take && (idx_reg == run_reg.count - cnt_t'(1));
    assign load     = in_valid_reg && (!run_valid_reg || run_done);
    assign in_take  = byte_ch.valid && byte_ch.ready;

    assign byte_ch.ready       = !in_valid_reg || load;
    assign char_ch.valid       = run_valid_reg;
    assign char_ch.character   = run_reg.chars[idx_reg];
    assign char_ch.last_of_run = (idx_reg == run_reg.count - cnt_t'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
            column_reg    <= COL_CLOSED;
            wrap_reg      <= WRAP_RESET;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (load)
                in_valid_reg <= 1'b0;

            if (load)
            begin
                run_valid_reg <= 1'b1;
                idx_reg       <= '0;
                column_reg    <= enc_column;
            end
            else if (run_done)
                run_valid_reg <= 1'b0;
            else if (out_take)
                idx_reg <= idx_reg + cnt_t'(1);

            if (wrap_we)
                wrap_reg <= wrap_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_ch.data_byte;
            in_eod_reg  <= byte_ch.end_of_data;
        end
        if (load)
            run_reg <= enc_run;
    end

endmodule

// ===== sv/cse_checker.sv =====
// Port-level checker for the string literal escaper and its bind statement.
`include "c_string_literal_escaper_defines.svh"

module cse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] character,
    input logic       last_of_run
);
    import cse_pkg::*;

    logic out_take;
    logic closed_reg;

    assign out_take = out_valid && out_ready;

    // Set after the newline that closes a literal; the next character opens a line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            closed_reg <= 1'b1;
        else if (out_take)
            closed_reg <= last_of_run && (character == CH_NEWLINE);
    end

    `CSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(character) && $stable(last_of_run), "output changed while stalled")
    // A space is only ever part of a line opening, so it never ends a run.
    `CSE_ASSERT_NOW(a_space_not_last, out_take && (character == CH_SPACE), !last_of_run, "space ended a run")
    `CSE_ASSERT_NOW(a_open_space, out_take && closed_reg, character == CH_SPACE, "new literal line did not start with a space")

endmodule

bind c_string_literal_escaper cse_checker u_cse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (char_ch.valid),
    .out_ready   (char_ch.ready),
    .character   (char_ch.character),
    .last_of_run (char_ch.last_of_run)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the C string literal escaper, with a character scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cse_pkg::*;

    localparam int    CLK_PERIOD    = 10;
    localparam int    RESET_CYCLES  = 7;
    localparam int    CYCLE_LIMIT   = 100000;
    localparam int    SETTLE_CYCLES = 8;
    localparam int    HOLD_CYCLES   = 150;
    localparam int    REPORT_MAX    = 10;
    localparam char_t CH_ZERO       = 7'h30;
    localparam char_t CH_BLANK      = 7'h20;

    // Predicts the character stream and matches it against the output transfers.
    class escape_scoreboard;
        typedef struct packed {
            char_t character;
            logic  last_of_run;
        } out_char_t;

        logic [7:0] wrap_col;
        logic [7:0] column;
        out_char_t  pending_chars[$];
        int         mismatches;

        function new();
            wrap_col   = WRAP_RESET;
            column     = COL_CLOSED;
            mismatches = 0;
        endfunction

        function void fail(string msg);
            if (mismatches < REPORT_MAX)
                $display("%s", msg);
            mismatches++;
        endfunction

        function void note_byte(logic [7:0] b, logic eod);
            char_t     run[$];
            int        width;
            int        sum;
            logic      plain;
            out_char_t oc;
            plain = b >= PLAIN_LO && b <= PLAIN_HI && b != BYTE_BSL && b != BYTE_QUOTE
                    && !(b >= DIGIT_LO && b <= DIGIT_HI);
            if (column == COL_CLOSED) begin
                run = '{CH_BLANK, CH_BLANK, CH_QUOTE};
                column = COL_OPEN;
            end
            else if (column > wrap_col) begin
                run = '{CH_QUOTE, CH_NEWLINE, CH_BLANK, CH_BLANK, CH_QUOTE};
                column = COL_OPEN;
            end
            if (plain) begin
                run.push_back(b[6:0]);
                width = 1;
            end
            else if (b == BYTE_BSL || b == BYTE_QUOTE) begin
                run.push_back(CH_BACKSLASH);
                run.push_back(b[6:0]);
                width = 2;
            end
            else begin
                run.push_back(CH_BACKSLASH);
                run.push_back(char_t'(CH_ZERO + b[7:6]));
                run.push_back(char_t'(CH_ZERO + b[5:3]));
                run.push_back(char_t'(CH_ZERO + b[2:0]));
                // The line length counts only the significant octal digits.
                width = 2 + int'(b > OCT1_MAX) + int'(b > OCT2_MAX);
            end
            sum = int'(column) + width;
            column = (sum > int'(COL_MAX)) ? COL_MAX : 8'(sum);
            if (eod) begin
                run.push_back(CH_QUOTE);
                run.push_back(CH_COMMA);
                run.push_back(CH_NEWLINE);
                column = COL_CLOSED;
            end
            foreach (run[i]) begin
                oc.character   = run[i];
                oc.last_of_run = (i == run.size() - 1);
                pending_chars.push_back(oc);
            end
        endfunction

        function void check_char(char_t ch, logic last);
            out_char_t oc;
            if (pending_chars.size() == 0) begin
                fail($sformatf("Unexpected character 0x%02h last_of_run=%0b", ch, last));
                return;
            end
            oc = pending_chars.pop_front();
            if (ch !== oc.character)
                fail($sformatf("character: expected 0x%02h, got 0x%02h",
                               oc.character, ch));
            if (last !== oc.last_of_run)
                fail($sformatf("last_of_run: expected %0b, got %0b (character 0x%02h)",
                               oc.last_of_run, last, oc.character));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       wrap_we;
    logic [7:0] wrap_wdata;
    logic       rx_hold;
    logic       hold_go;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         cycle_count = 0;

    cse_byte_if byte_ch();
    cse_char_if char_ch();

    escape_scoreboard sb = new();

    c_string_literal_escaper dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .char_ch    (char_ch),
        .wrap_we    (wrap_we),
        .wrap_wdata (wrap_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Both channels are sampled at the edge, before any update of that edge lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
                sb.note_byte(byte_ch.data_byte, byte_ch.end_of_data);
            if (char_ch.valid && char_ch.ready)
                sb.check_char(char_ch.character, char_ch.last_of_run);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            char_ch.ready <= 1'b0;
        else
            char_ch.ready <= !rx_hold && ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // Long receiver hold-off, so the block fills up and pushes back on its input.
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic eod);
        while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.end_of_data <= eod;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9, 0))
            0:       return 8'($urandom_range(int'(OCT1_MAX), 0));
            1:       return 8'($urandom_range(int'(OCT2_MAX), int'(OCT1_MAX) + 1));
            2:       return BYTE_BSL;
            3:       return BYTE_QUOTE;
            4:       return 8'($urandom_range(int'(DIGIT_HI), int'(DIGIT_LO)));
            5, 6:    return 8'($urandom_range(int'(PLAIN_HI), int'(PLAIN_LO)));
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic send_random(input int count, input int eod_one_in);
        repeat (count)
            send_byte(pick_byte(), $urandom_range(eod_one_in - 1, 0) == 0);
    endtask

    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wrap(input logic [7:0] value);
        wrap_we    <= 1'b1;
        wrap_wdata <= value;
        @(posedge clk);
        wrap_we       <= 1'b0;
        sb.wrap_col    = value;
    endtask

    initial
    begin
        logic [8:0] directed[$];
        directed = '{9'h000, 9'h007, 9'h008, 9'h03F, 9'h040, 9'h0FF, 9'h020, 9'h07F,
                     9'h021, 9'h07E, 9'h030, 9'h039, 9'h05C, 9'h022, 9'h141, 9'h12F,
                     9'h05B, 9'h02F, 9'h03A, 9'h0AA, 9'h055, 9'h180};
        rst_n               = 1'b0;
        wrap_we             = 1'b0;
        wrap_wdata          = 8'd0;
        hold_go             = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'd0;
        byte_ch.end_of_data = 1'b0;
        tx_idle_pct         = 27;
        rx_idle_pct         = 73;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Escape classes, octal width steps and literal openings at the reset wrap column.
        foreach (directed[k])
            send_byte(directed[k][7:0], directed[k][8]);
        wait_for_drain();

        write_wrap(8'd3);
        send_random(20, 4);
        wait_for_drain();

        tx_idle_pct = 73;
        rx_idle_pct = 27;

        // A long line of four-column escapes drives the column into saturation.
        write_wrap(COL_MAX);
        repeat (64)
            send_byte(8'($urandom_range(255, 127)), 1'b0);
        wait_for_drain();

        // The open line is already past the new limit, so the next byte breaks it.
        write_wrap(8'd250);
        send_random(20, 8);
        wait_for_drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;

        write_wrap(8'd0);
        send_random(15, 4);
        wait_for_drain();

        write_wrap(8'($urandom_range(250, 3)));
        hold_go = 1'b1;
        send_random(30, 6);
        wait_for_drain();

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
